// ----- hdl/llwp_pkg.sv -----
// Shared types and constants of the least-loaded worker picker.
`default_nettype none
package llwp_pkg;

  localparam int unsigned WORKER_IDX_W = 4;
  localparam int unsigned COUNT_OUT_W  = 16;
  localparam int unsigned PROCESSED_W  = 32;
  localparam int unsigned ACTION_W     = 2;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_LEAST_LOADED_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORKER_COUNT      = 1'd1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PICK     = 2'd0,
    ACT_COMPLETE = 2'd1,
    ACT_READ     = 2'd2
  } action_e;

  typedef struct packed {
    logic [WORKER_IDX_W-1:0] chosen_worker;
    logic [COUNT_OUT_W-1:0]  inflight_count;
    logic [PROCESSED_W-1:0]  processed_count;
    logic                    error;
  } rsp_t;

endpackage
`default_nettype wire

// ----- hdl/llwp_req_if.sv -----
// Request channel: action code and worker index with valid/ready handshake.
`default_nettype none
interface llwp_req_if;
  logic                                valid;
  logic                                ready;
  logic [llwp_pkg::ACTION_W-1:0]       action;
  logic [llwp_pkg::WORKER_IDX_W-1:0]   worker_index;

  modport source (output valid, output action, output worker_index, input ready);
  modport sink   (input valid, input action, input worker_index, output ready);
endinterface
`default_nettype wire

// ----- hdl/llwp_rsp_if.sv -----
// Result channel: chosen worker, its counters and the error flag.
`default_nettype none
interface llwp_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [llwp_pkg::WORKER_IDX_W-1:0]   chosen_worker;
  logic [llwp_pkg::COUNT_OUT_W-1:0]    inflight_count;
  logic [llwp_pkg::PROCESSED_W-1:0]    processed_count;
  logic                                error;

  modport source (output valid, output chosen_worker, output inflight_count,
                  output processed_count, output error, input ready);
  modport sink   (input valid, input chosen_worker, input inflight_count,
                  input processed_count, input error, output ready);
endinterface
`default_nettype wire

// ----- hdl/llwp_counter_mem.sv -----
// Counter memory: one synchronous-read entry per worker with reset-cleared valid bits.
`default_nettype none
module llwp_counter_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned AW     = 4,
  parameter int unsigned INFL_W = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               rd_en_i,
  input  wire logic [AW-1:0]                      rd_addr_i,
  output logic      [INFL_W-1:0]                  rd_infl_o,
  output logic      [llwp_pkg::PROCESSED_W-1:0]   rd_proc_o,
  input  wire logic                               wr_en_i,
  input  wire logic [AW-1:0]                      wr_addr_i,
  input  wire logic [INFL_W-1:0]                  wr_infl_i,
  input  wire logic [llwp_pkg::PROCESSED_W-1:0]   wr_proc_i
);

  localparam int unsigned DW = llwp_pkg::PROCESSED_W + INFL_W;

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] entry_vld_q;
  logic [DW-1:0]    rd_data_q;
  logic             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_proc_i, wr_infl_i};
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
      rd_vld_q  <= entry_vld_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_vld_q <= '0;
    end else if (wr_en_i) begin
      entry_vld_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_infl_o = rd_vld_q ? rd_data_q[INFL_W-1:0] : '0;
  assign rd_proc_o = rd_vld_q ? rd_data_q[DW-1:INFL_W] : '0;

endmodule
`default_nettype wire

// ----- hdl/llwp_out_reg.sv -----
// Output register that holds one result item until the sink takes it.
`default_nettype none
module llwp_out_reg (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            load_i,
  input  wire llwp_pkg::rsp_t  data_i,
  output logic                 free_o,
  llwp_rsp_if.source           rsp
);

  logic           valid_q;
  llwp_pkg::rsp_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (rsp.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign free_o              = !valid_q || rsp.ready;
  assign rsp.valid           = valid_q;
  assign rsp.chosen_worker   = data_q.chosen_worker;
  assign rsp.inflight_count  = data_q.inflight_count;
  assign rsp.processed_count = data_q.processed_count;
  assign rsp.error           = data_q.error;

endmodule
`default_nettype wire

// ----- hdl/least_loaded_worker_picker.sv -----
// Top level of the least-loaded worker picker: sequencer, configuration and counter memory.
// The block takes one request item at a time and returns one result item for each. The
// per-worker in-flight and processed counters live in a single memory with a registered
// read. A least-loaded pick reads one counter per cycle over the active workers
// (worker_count, raised to one and capped at MAX_WORKERS) in ST_SCAN, then passes
// through ST_UPDATE and ST_HOLD; a round-robin pick, a completion or a read passes
// through ST_FETCH, ST_UPDATE and ST_HOLD, and a completion or read with an index out
// of range goes straight to ST_HOLD. The next item is accepted at the earliest with its result.
// A finished result waits in an output register, and the next item can be accepted while it
// waits. Counters read as zero after reset, with no clearing pass.
`default_nettype none
module least_loaded_worker_picker #(
  parameter int unsigned MAX_WORKERS   = 16,
  parameter int unsigned INFLIGHT_BITS = 16
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  llwp_req_if.sink                                  req_i,
  llwp_rsp_if.source                                rsp_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [llwp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [llwp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned NW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned CW = (NW > llwp_pkg::CFG_DATA_W) ? NW : llwp_pkg::CFG_DATA_W;
  localparam int unsigned PW = llwp_pkg::PROCESSED_W;
  localparam int unsigned IW = llwp_pkg::WORKER_IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH,
    ST_UPDATE,
    ST_HOLD
  } state_e;

  state_e                          state_q, state_d;
  llwp_pkg::action_e               op_q, op_d;
  logic                            mode_q;
  logic [llwp_pkg::CFG_DATA_W-1:0] wcount_q;
  logic [AW-1:0]                   ptr_q, ptr_d;
  logic [AW-1:0]                   who_q, who_d;
  logic [IW-1:0]                   idx_q, idx_d;
  logic [NW-1:0]                   issue_q, issue_d;
  logic [AW-1:0]                   cmp_idx_q, cmp_idx_d;
  logic [INFLIGHT_BITS-1:0]        best_infl_q, best_infl_d;
  logic [PW-1:0]                   best_proc_q, best_proc_d;
  llwp_pkg::rsp_t                  res_q, res_d;

  logic [CW-1:0]                   wc_ext;
  logic [CW-1:0]                   n_ext;
  logic [CW-1:0]                   idx_ext;
  logic                            accept;
  llwp_pkg::action_e               req_op;
  logic [AW-1:0]                   rr_sel;
  logic [AW-1:0]                   rr_next;

  logic                            mem_rd_en;
  logic [AW-1:0]                   mem_rd_addr;
  logic [INFLIGHT_BITS-1:0]        mem_rd_infl;
  logic [PW-1:0]                   mem_rd_proc;
  logic                            mem_we;
  logic [INFLIGHT_BITS-1:0]        mem_wr_infl;
  logic [PW-1:0]                   mem_wr_proc;

  logic                            out_load;
  logic                            out_free;

  function automatic logic [llwp_pkg::COUNT_OUT_W-1:0] COUNT_CAST(
    input logic [INFLIGHT_BITS-1:0] v
  );
    return llwp_pkg::COUNT_OUT_W'(v);
  endfunction

  llwp_counter_mem #(
    .DEPTH  (MAX_WORKERS),
    .AW     (AW),
    .INFL_W (INFLIGHT_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_infl_o (mem_rd_infl),
    .rd_proc_o (mem_rd_proc),
    .wr_en_i   (mem_we),
    .wr_addr_i (who_q),
    .wr_infl_i (mem_wr_infl),
    .wr_proc_i (mem_wr_proc)
  );

  llwp_out_reg u_out (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .data_i (res_q),
    .free_o (out_free),
    .rsp    (rsp_o)
  );

  assign wc_ext  = CW'(wcount_q);
  assign n_ext   = (wc_ext == '0) ? CW'(1)
                 : ((wc_ext > CW'(MAX_WORKERS)) ? CW'(MAX_WORKERS) : wc_ext);
  assign idx_ext = CW'(req_i.worker_index);
  assign accept  = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign rr_sel  = (CW'(ptr_q) < n_ext) ? ptr_q : '0;
  assign rr_next = ((CW'(rr_sel) + CW'(1)) >= n_ext) ? '0 : AW'(CW'(rr_sel) + CW'(1));

  always_comb begin
    case (req_i.action)
      llwp_pkg::ACT_PICK:     req_op = llwp_pkg::ACT_PICK;
      llwp_pkg::ACT_COMPLETE: req_op = llwp_pkg::ACT_COMPLETE;
      default:                req_op = llwp_pkg::ACT_READ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    ptr_d       = ptr_q;
    who_d       = who_q;
    idx_d       = idx_q;
    issue_d     = issue_q;
    cmp_idx_d   = cmp_idx_q;
    best_infl_d = best_infl_q;
    best_proc_d = best_proc_q;
    res_d       = res_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_we      = 1'b0;
    mem_wr_infl = best_infl_q;
    mem_wr_proc = best_proc_q;
    out_load    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d  = req_op;
          idx_d = req_i.worker_index;
          if (req_op == llwp_pkg::ACT_PICK) begin
            if (mode_q) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = '0;
              cmp_idx_d   = '0;
              issue_d     = NW'(1);
              state_d     = ST_SCAN;
            end else begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = rr_sel;
              who_d       = rr_sel;
              ptr_d       = rr_next;
              state_d     = ST_FETCH;
            end
          end else if (idx_ext >= n_ext) begin
            res_d.chosen_worker   = req_i.worker_index;
            res_d.inflight_count  = '0;
            res_d.processed_count = '0;
            res_d.error           = 1'b1;
            state_d               = ST_HOLD;
          end else begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = AW'(idx_ext);
            who_d       = AW'(idx_ext);
            state_d     = ST_FETCH;
          end
        end
      end
      ST_SCAN: begin
        if ((cmp_idx_q == '0) || (mem_rd_infl < best_infl_q)) begin
          best_infl_d = mem_rd_infl;
          best_proc_d = mem_rd_proc;
          who_d       = cmp_idx_q;
        end
        if (CW'(issue_q) < n_ext) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = issue_q[AW-1:0];
          cmp_idx_d   = issue_q[AW-1:0];
          issue_d     = issue_q + NW'(1);
        end else begin
          state_d = ST_UPDATE;
        end
      end
      ST_FETCH: begin
        best_infl_d = mem_rd_infl;
        best_proc_d = mem_rd_proc;
        state_d     = ST_UPDATE;
      end
      ST_UPDATE: begin
        res_d.chosen_worker   = idx_q;
        res_d.inflight_count  = COUNT_CAST(best_infl_q);
        res_d.processed_count = best_proc_q;
        res_d.error           = 1'b0;
        case (op_q)
          llwp_pkg::ACT_PICK: begin
            if (best_infl_q != '1) begin
              mem_wr_infl = best_infl_q + INFLIGHT_BITS'(1);
            end
            mem_we                = 1'b1;
            res_d.chosen_worker   = IW'(who_q);
            res_d.inflight_count  = COUNT_CAST(mem_wr_infl);
          end
          llwp_pkg::ACT_COMPLETE: begin
            if (best_infl_q == '0) begin
              res_d.error = 1'b1;
            end else begin
              mem_wr_infl = best_infl_q - INFLIGHT_BITS'(1);
              if (best_proc_q != '1) begin
                mem_wr_proc = best_proc_q + PW'(1);
              end
              mem_we                = 1'b1;
              res_d.inflight_count  = COUNT_CAST(mem_wr_infl);
              res_d.processed_count = mem_wr_proc;
            end
          end
          default: begin
          end
        endcase
        state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= llwp_pkg::ACT_PICK;
      ptr_q    <= '0;
      issue_q  <= '0;
      mode_q   <= 1'b1;
      wcount_q <= llwp_pkg::CFG_DATA_W'(1);
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ptr_q   <= ptr_d;
      issue_q <= issue_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          llwp_pkg::CFG_LEAST_LOADED_MODE: mode_q   <= cfg_data_i[0];
          llwp_pkg::CFG_WORKER_COUNT:      wcount_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    who_q       <= who_d;
    idx_q       <= idx_d;
    cmp_idx_q   <= cmp_idx_d;
    best_infl_q <= best_infl_d;
    best_proc_q <= best_proc_d;
    res_q       <= res_d;
  end

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("Request accepted while an item is in progress.");

  a_pick_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && op_q == llwp_pkg::ACT_PICK) |-> (CW'(who_q) < n_ext))
    else $error("Picked worker lies beyond the active worker count.");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> $past(state_q == ST_HOLD))
    else $error("Result item appeared without a finished update.");

endmodule
`default_nettype wire
